[hdl/bmhq_pkg.sv]
// Shared types and constants for the binary max-heap request queue.
package bmhq_pkg;

	localparam int PRIO_W = 8;
	localparam int ID_W   = 14;
	localparam int TOT_W  = 7;
	localparam int QDEPTH = 2;
	localparam int QAW    = $clog2(QDEPTH);

	typedef struct packed {
		logic signed [PRIO_W-1:0] prio;
		logic [ID_W-1:0]          id;
		logic                     wr;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic {
		OP_INSERT  = 1'b0,
		OP_EXTRACT = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_UP,
		S_DOWN,
		S_DONE
	} state_t;

	typedef struct packed {
		op_t    op;
		entry_t entry;
	} cmd_t;

	typedef struct packed {
		status_t          status;
		entry_t           taken;
		logic [TOT_W-1:0] total;
		entry_t           top;
	} result_t;

endpackage

[hdl/bmhq_ram.sv]
// Generic RAM: one write port, two registered read ports.
module bmhq_ram #(
	parameter int WIDTH = 23,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd0_q;
	logic [WIDTH-1:0] rd1_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd0_q <= mem_q[raddr0];
		rd1_q <= mem_q[raddr1];
	end

	assign rdata0 = rd0_q;
	assign rdata1 = rd1_q;

endmodule

[hdl/bmhq_front.sv]
// Front end: takes requests, decodes the action and queues commands.
module bmhq_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        action,
	input  logic signed [7:0]           priority_req,
	input  logic [13:0]                 requester_id,
	input  logic                        is_write,
	output logic                        cmd_valid,
	input  logic                        cmd_ready,
	output bmhq_pkg::cmd_t              cmd
);

	bmhq_pkg::cmd_t               slot_q [bmhq_pkg::QDEPTH];
	logic [bmhq_pkg::QAW-1:0]     wr_ptr_q;
	logic [bmhq_pkg::QAW-1:0]     rd_ptr_q;
	logic [bmhq_pkg::QAW:0]       fill_q;
	bmhq_pkg::cmd_t               new_cmd;
	logic                         push;
	logic                         pop;

	always_comb begin
		new_cmd.op         = action ? bmhq_pkg::OP_EXTRACT : bmhq_pkg::OP_INSERT;
		new_cmd.entry.prio = priority_req;
		new_cmd.entry.id   = requester_id;
		new_cmd.entry.wr   = is_write;
	end

	assign in_ready  = (fill_q != (bmhq_pkg::QAW+1)'(bmhq_pkg::QDEPTH));
	assign cmd_valid = (fill_q != '0);
	assign cmd       = slot_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

[hdl/bmhq_back.sv]
// Back end: heap sift engine over the entry RAM and the result register.
module bmhq_back #(
	parameter int CAPACITY = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  bmhq_pkg::cmd_t       cmd,
	output logic                 res_valid,
	input  logic                 res_ready,
	output bmhq_pkg::result_t    res
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = AW + 2;

	bmhq_pkg::state_t  state_q, state_n;
	logic [CW-1:0]     count_q, count_n;
	logic [AW-1:0]     pos_q, pos_n;
	bmhq_pkg::entry_t  item_q, item_n;
	bmhq_pkg::entry_t  top_q;
	bmhq_pkg::entry_t  taken_q, taken_n;
	bmhq_pkg::status_t stat_q, stat_n;
	bmhq_pkg::result_t res_q;
	logic              res_valid_q;
	logic              res_load;

	logic              we;
	logic [AW-1:0]     waddr;
	bmhq_pkg::entry_t  wdata;
	logic [AW-1:0]     raddr0, raddr1;
	logic [bmhq_pkg::ENTRY_W-1:0] rdata0, rdata1;
	bmhq_pkg::entry_t  lv, rv, bv;

	logic [PW-1:0]     pos_w, left_w, right_w, last_w, best_w, par_w;
	logic              pick_right;

	bmhq_ram #(
		.WIDTH(bmhq_pkg::ENTRY_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr0(raddr0),
		.raddr1(raddr1),
		.rdata0(rdata0),
		.rdata1(rdata1)
	);

	assign lv = bmhq_pkg::entry_t'(rdata0);
	assign rv = bmhq_pkg::entry_t'(rdata1);

	always_comb begin
		pos_w      = PW'(pos_q);
		left_w     = {pos_w[PW-2:0], 1'b1};
		right_w    = left_w + 1'b1;
		last_w     = PW'(count_q) - 1'b1;
		pick_right = (left_w != last_w) && ($signed(lv.prio) <= $signed(rv.prio));
		best_w     = pick_right ? right_w : left_w;
		bv         = pick_right ? rv : lv;
		par_w      = (pos_w - 1'b1) >> 1;
	end

	assign cmd_ready = (state_q == bmhq_pkg::S_IDLE);
	assign res_load  = (state_q == bmhq_pkg::S_DONE) && (!res_valid_q || res_ready);

	always_comb begin
		state_n = state_q;
		count_n = count_q;
		pos_n   = pos_q;
		item_n  = item_q;
		taken_n = taken_q;
		stat_n  = stat_q;
		we      = 1'b0;
		waddr   = pos_q;
		wdata   = item_q;
		raddr0  = '0;
		raddr1  = '0;
		case (state_q)
			bmhq_pkg::S_IDLE: begin
				if (cmd_valid) begin
					taken_n = '0;
					stat_n  = bmhq_pkg::ST_DONE;
					if (cmd.op == bmhq_pkg::OP_INSERT) begin
						if (count_q == CW'(CAPACITY)) begin
							stat_n  = bmhq_pkg::ST_FULL;
							state_n = bmhq_pkg::S_DONE;
						end else begin
							item_n  = cmd.entry;
							pos_n   = AW'(count_q);
							count_n = count_q + 1'b1;
							raddr0  = AW'((PW'(count_q) - 1'b1) >> 1);
							state_n = bmhq_pkg::S_UP;
						end
					end else begin
						if (count_q == '0) begin
							stat_n  = bmhq_pkg::ST_EMPTY;
							state_n = bmhq_pkg::S_DONE;
						end else begin
							taken_n = top_q;
							count_n = count_q - 1'b1;
							raddr0  = AW'(count_q - 1'b1);
							state_n = (count_q == CW'(1)) ? bmhq_pkg::S_DONE
							                              : bmhq_pkg::S_LOAD;
						end
					end
				end
			end
			bmhq_pkg::S_LOAD: begin
				item_n  = lv;
				pos_n   = '0;
				raddr0  = AW'(1);
				raddr1  = AW'(2);
				state_n = bmhq_pkg::S_DOWN;
			end
			bmhq_pkg::S_UP: begin
				if (pos_q == '0) begin
					we      = 1'b1;
					state_n = bmhq_pkg::S_DONE;
				end else if ($signed(lv.prio) < $signed(item_q.prio)) begin
					we      = 1'b1;
					wdata   = lv;
					pos_n   = AW'(par_w);
					raddr0  = AW'((par_w - 1'b1) >> 1);
				end else begin
					we      = 1'b1;
					state_n = bmhq_pkg::S_DONE;
				end
			end
			bmhq_pkg::S_DOWN: begin
				if (left_w > last_w) begin
					we      = 1'b1;
					state_n = bmhq_pkg::S_DONE;
				end else if ($signed(bv.prio) > $signed(item_q.prio)) begin
					we      = 1'b1;
					wdata   = bv;
					pos_n   = AW'(best_w);
					raddr0  = AW'({best_w[PW-2:0], 1'b1});
					raddr1  = AW'({best_w[PW-2:0], 1'b1} + 1'b1);
				end else begin
					we      = 1'b1;
					state_n = bmhq_pkg::S_DONE;
				end
			end
			bmhq_pkg::S_DONE: begin
				if (res_load) begin
					state_n = bmhq_pkg::S_IDLE;
				end
			end
			default: begin
				state_n = bmhq_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bmhq_pkg::S_IDLE;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			count_q <= count_n;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_q   <= pos_n;
		item_q  <= item_n;
		taken_q <= taken_n;
		stat_q  <= stat_n;
		if (we && (waddr == '0)) begin
			top_q <= wdata;
		end
		if (res_load) begin
			res_q.status <= stat_q;
			res_q.taken  <= taken_q;
			res_q.total  <= bmhq_pkg::TOT_W'(count_q);
			res_q.top    <= (count_q != '0) ? top_q : '0;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

[hdl/binary_max_heap_queue_top.sv]
// Insert runs S_UP, climbing L levels, then S_DONE; extract runs S_LOAD and S_DOWN,
// descending L levels, then S_DONE; empty/full/last go straight to S_DONE.
// S_DONE loads the result register; a new request is taken only in S_IDLE. The sift loop
// moves one level per cycle, up through one entry-RAM read port, down through both.
// Reset (arst_n low, async) empties the heap and the request queue; RAM is not cleared.
module binary_max_heap_queue_top #(
	parameter int CAPACITY = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              action,
	input  logic signed [7:0] priority_req,
	input  logic [13:0]       requester_id,
	input  logic              is_write,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        status,
	output logic signed [7:0] out_priority,
	output logic [13:0]       out_requester_id,
	output logic              out_is_write,
	output logic [6:0]        entry_total,
	output logic signed [7:0] top_priority,
	output logic [13:0]       top_requester_id,
	output logic              top_is_write
);

	logic              cmd_valid;
	logic              cmd_ready;
	bmhq_pkg::cmd_t    cmd;
	bmhq_pkg::result_t res;

	bmhq_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.priority_req(priority_req),
		.requester_id(requester_id),
		.is_write    (is_write),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.cmd         (cmd)
	);

	bmhq_back #(
		.CAPACITY(CAPACITY)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.res_valid(out_valid),
		.res_ready(out_ready),
		.res      (res)
	);

	assign status           = res.status;
	assign out_priority     = res.taken.prio;
	assign out_requester_id = res.taken.id;
	assign out_is_write     = res.taken.wr;
	assign entry_total      = res.total;
	assign top_priority     = res.top.prio;
	assign top_requester_id = res.top.id;
	assign top_is_write     = res.top.wr;

endmodule

[hdl/bmhq_chk.sv]
// Port-level checker for the heap request queue, bound to the top level.
module bmhq_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic [1:0]        status,
	input logic signed [7:0] out_priority,
	input logic [13:0]       out_requester_id,
	input logic              out_is_write,
	input logic [6:0]        entry_total,
	input logic signed [7:0] top_priority,
	input logic [13:0]       top_requester_id,
	input logic              top_is_write
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(entry_total))
		else $error("result dropped or changed under stall");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == bmhq_pkg::ST_DONE || status == bmhq_pkg::ST_EMPTY
		               || status == bmhq_pkg::ST_FULL))
		else $error("unknown status code");

	a_empty_extract: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == bmhq_pkg::ST_EMPTY |->
		entry_total == 7'd0 && out_priority == 8'sd0 && out_requester_id == 14'd0
		&& !out_is_write)
		else $error("extract on empty reported data");

	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && entry_total == 7'd0 |->
		top_priority == 8'sd0 && top_requester_id == 14'd0 && !top_is_write)
		else $error("empty heap reported a top entry");

endmodule

bind binary_max_heap_queue_top bmhq_chk u_bmhq_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.status          (status),
	.out_priority    (out_priority),
	.out_requester_id(out_requester_id),
	.out_is_write    (out_is_write),
	.entry_total     (entry_total),
	.top_priority    (top_priority),
	.top_requester_id(top_requester_id),
	.top_is_write    (top_is_write)
);
